### hw/rtl/pfla_pkg.sv
// pfla_pkg: constants, codes and controller/datapath interface types for the page allocator
// used by pfla_ctrl, pfla_dpath and page_free_list_allocator; no dependencies
`default_nettype none

package pfla_pkg;

  // pool geometry
  localparam int unsigned PAGE_COUNT = 4096;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned ADDR_W     = $clog2(PAGE_COUNT);      // link memory address
  localparam int unsigned LINK_W     = $clog2(PAGE_COUNT + 1);  // page index incl. none

  localparam logic [LINK_W-1:0] NONE_IDX = LINK_W'(PAGE_COUNT);

  // physical placement of the pool
  localparam longint unsigned RAM_BASE     = 64'h10_0000;
  localparam longint unsigned MIB_BYTES    = 1024 * 1024;
  localparam longint unsigned BASE_ALIGNED =
    ((RAM_BASE + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
  localparam int unsigned MIB_SHIFT = $clog2(MIB_BYTES) - PAGE_SHIFT;

  // field widths
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned REQ_W       = COUNT_W + MIB_SHIFT;
  localparam int unsigned RAM_W       = 32;
  localparam int unsigned HADDR_W     = 32;
  localparam int unsigned FBYTES_W    = 25;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 96;

  localparam logic [RAM_W-1:0] RAM_SIZE_RST = 32'd16777216;

  typedef enum logic [FUNC_W-1:0] {
    FN_INIT        = 2'd0,
    FN_ALLOC_PAGES = 2'd1,
    FN_ALLOC_MIB   = 2'd2,
    FN_FREE        = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    RS_OK       = 2'd0,
    RS_ZERO     = 2'd1,
    RS_SHORT    = 2'd2,
    RS_NO_CHAIN = 2'd3
  } rstat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_INIT,
    S_AWALK,
    S_FWALK,
    S_RESULT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_START_INIT,
    OP_INIT_STEP,
    OP_START_ALLOC,
    OP_ALLOC_STEP,
    OP_ALLOC_END,
    OP_START_FREE,
    OP_FREE_STEP,
    OP_FREE_END,
    OP_FAIL,
    OP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    rstat_t fail_code;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  req_zero;
    logic  alloc_short;
    logic  chain_bad;
    logic  walk_done;
    logic  link_bad;
    logic  free_stop;
    logic  init_done;
    logic  out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

### hw/rtl/pfla_ctrl.sv
// pfla_ctrl: sequencing state machine of the page allocator
// depends on pfla_pkg; drives pfla_dpath through dp_cmd_t and reads dp_sts_t
`default_nettype none

module pfla_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  pfla_pkg::dp_sts_t sts,
  output pfla_pkg::dp_cmd_t cmd
);

  pfla_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfla_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfla_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = pfla_pkg::S_CHECK;
      end
      pfla_pkg::S_CHECK: begin
        unique case (sts.func)
          pfla_pkg::FN_INIT: state_nxt = pfla_pkg::S_INIT;
          pfla_pkg::FN_ALLOC_PAGES,
          pfla_pkg::FN_ALLOC_MIB: begin
            if (sts.req_zero || sts.alloc_short) state_nxt = pfla_pkg::S_RESULT;
            else state_nxt = pfla_pkg::S_AWALK;
          end
          pfla_pkg::FN_FREE: begin
            if (sts.chain_bad) state_nxt = pfla_pkg::S_RESULT;
            else state_nxt = pfla_pkg::S_FWALK;
          end
          default: state_nxt = pfla_pkg::S_RESULT;
        endcase
      end
      pfla_pkg::S_INIT: begin
        if (sts.init_done) state_nxt = pfla_pkg::S_RESULT;
      end
      pfla_pkg::S_AWALK: begin
        if (sts.walk_done || sts.link_bad) state_nxt = pfla_pkg::S_RESULT;
      end
      pfla_pkg::S_FWALK: begin
        if (sts.free_stop) state_nxt = pfla_pkg::S_RESULT;
      end
      pfla_pkg::S_RESULT: begin
        if (sts.out_free) state_nxt = pfla_pkg::S_IDLE;
      end
      default: state_nxt = pfla_pkg::S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    in_tready     = 1'b0;
    cmd.op        = pfla_pkg::OP_NONE;
    cmd.fail_code = pfla_pkg::RS_OK;
    unique case (state_r)
      pfla_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = pfla_pkg::OP_ACCEPT;
      end
      pfla_pkg::S_CHECK: begin
        unique case (sts.func)
          pfla_pkg::FN_INIT: cmd.op = pfla_pkg::OP_START_INIT;
          pfla_pkg::FN_ALLOC_PAGES,
          pfla_pkg::FN_ALLOC_MIB: begin
            priority if (sts.req_zero) begin
              cmd.op        = pfla_pkg::OP_FAIL;
              cmd.fail_code = pfla_pkg::RS_ZERO;
            end else if (sts.alloc_short) begin
              cmd.op        = pfla_pkg::OP_FAIL;
              cmd.fail_code = pfla_pkg::RS_SHORT;
            end else begin
              cmd.op = pfla_pkg::OP_START_ALLOC;
            end
          end
          pfla_pkg::FN_FREE: begin
            if (sts.chain_bad) begin
              cmd.op        = pfla_pkg::OP_FAIL;
              cmd.fail_code = pfla_pkg::RS_NO_CHAIN;
            end else begin
              cmd.op = pfla_pkg::OP_START_FREE;
            end
          end
          default: cmd.op = pfla_pkg::OP_NONE;
        endcase
      end
      pfla_pkg::S_INIT: begin
        if (!sts.init_done) cmd.op = pfla_pkg::OP_INIT_STEP;
      end
      pfla_pkg::S_AWALK: begin
        priority if (sts.walk_done) begin
          cmd.op = pfla_pkg::OP_ALLOC_END;
        end else if (sts.link_bad) begin
          cmd.op        = pfla_pkg::OP_FAIL;
          cmd.fail_code = pfla_pkg::RS_SHORT;
        end else begin
          cmd.op = pfla_pkg::OP_ALLOC_STEP;
        end
      end
      pfla_pkg::S_FWALK: begin
        if (sts.free_stop) cmd.op = pfla_pkg::OP_FREE_END;
        else cmd.op = pfla_pkg::OP_FREE_STEP;
      end
      pfla_pkg::S_RESULT: begin
        if (sts.out_free) cmd.op = pfla_pkg::OP_LOAD_OUT;
      end
      default: cmd.op = pfla_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/pfla_dpath.sv
// pfla_dpath: link memory, list registers, walk pointer and result register
// depends on pfla_pkg; commanded by pfla_ctrl
`default_nettype none

module pfla_dpath (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  pfla_pkg::dp_cmd_t                   cmd,
  output pfla_pkg::dp_sts_t                   sts,
  input  wire  [pfla_pkg::FUNC_W-1:0]         in_tuser,
  input  wire  [pfla_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire                                 cfg_wr_en,
  input  wire  [pfla_pkg::RAM_W-1:0]          cfg_wr_data,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [1:0]                          out_tuser,
  output logic [pfla_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int unsigned LW = pfla_pkg::LINK_W;
  localparam int unsigned AW = pfla_pkg::ADDR_W;
  localparam int unsigned RW = pfla_pkg::REQ_W;

  // link memory
  logic [LW-1:0] link_mem [pfla_pkg::PAGE_COUNT];
  logic [LW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [LW-1:0] wr_data;

  // list state and per-item registers
  logic [pfla_pkg::RAM_W-1:0] ram_size_r;
  logic [LW-1:0]              free_head_r, free_head_nxt;
  logic [LW-1:0]              free_count_r, free_count_nxt;
  logic [LW-1:0]              page_total_r, page_total_nxt;
  pfla_pkg::func_t            func_r;
  logic [RW-1:0]              req_r;
  logic [LW-1:0]              chain_r;
  logic [LW-1:0]              cur_r, cur_nxt;
  logic [LW-1:0]              cnt_r, cnt_nxt;
  pfla_pkg::rstat_t           rstat_r, rstat_nxt;
  logic [LW-1:0]              head_r, head_nxt;

  // output register
  logic                             out_valid_r;
  logic [1:0]                       out_user_r;
  logic [pfla_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic                      link_in_pool;
  logic [LW:0]               free_sum;
  logic [pfla_pkg::RAM_W:0]  limit;
  logic [pfla_pkg::RAM_W:0]  span;
  logic [pfla_pkg::RAM_W:0]  pages_fit;
  logic [LW-1:0]             init_pages;
  logic [LW-1:0]             init_link;
  logic                      head_ok;
  logic [pfla_pkg::HADDR_W-1:0] head_addr;
  logic [pfla_pkg::FBYTES_W-1:0] free_bytes;

  assign link_in_pool = rd_data_r < page_total_r;
  assign free_sum     = {1'b0, free_count_r} + {1'b0, cnt_r};

  // pages that fit between the aligned base and the end of ram
  assign limit = (pfla_pkg::RAM_W+1)'(pfla_pkg::RAM_BASE) + {1'b0, ram_size_r};
  assign span  = limit - (pfla_pkg::RAM_W+1)'(pfla_pkg::BASE_ALIGNED);
  always_comb begin
    if (limit >= (pfla_pkg::RAM_W+1)'(pfla_pkg::BASE_ALIGNED + pfla_pkg::PAGE_BYTES)) begin
      pages_fit = span >> pfla_pkg::PAGE_SHIFT;
    end else begin
      pages_fit = '0;
    end
    if (pages_fit > (pfla_pkg::RAM_W+1)'(pfla_pkg::PAGE_COUNT)) begin
      init_pages = pfla_pkg::NONE_IDX;
    end else begin
      init_pages = pages_fit[LW-1:0];
    end
  end

  assign init_link = (LW'(cnt_r + 1'b1) < page_total_r) ? LW'(cnt_r + 1'b1) : pfla_pkg::NONE_IDX;

  // status towards the controller
  always_comb begin
    sts.func        = func_r;
    sts.req_zero    = (req_r == '0);
    sts.alloc_short = (req_r > RW'(free_count_r)) || (req_r > RW'(page_total_r)) ||
                      (free_head_r >= page_total_r);
    sts.chain_bad   = (chain_r >= page_total_r);
    sts.walk_done   = (cnt_r == '0);
    sts.link_bad    = !link_in_pool;
    sts.free_stop   = !link_in_pool || (cnt_r >= page_total_r);
    sts.init_done   = (cnt_r == page_total_r);
    sts.out_free    = !out_valid_r || out_tready;
  end

  // memory port control
  always_comb begin
    rd_addr = rd_data_r[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = cur_r[AW-1:0];
    wr_data = pfla_pkg::NONE_IDX;
    unique case (cmd.op)
      pfla_pkg::OP_START_ALLOC: rd_addr = free_head_r[AW-1:0];
      pfla_pkg::OP_START_FREE:  rd_addr = chain_r[AW-1:0];
      pfla_pkg::OP_INIT_STEP: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[AW-1:0];
        wr_data = init_link;
      end
      pfla_pkg::OP_ALLOC_END: begin
        wr_en   = 1'b1;
        wr_data = pfla_pkg::NONE_IDX;
      end
      pfla_pkg::OP_FREE_END: begin
        wr_en   = 1'b1;
        wr_data = free_head_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) link_mem[wr_addr] <= wr_data;
    rd_data_r <= link_mem[rd_addr];
  end

  // list and walk registers
  always_comb begin
    free_head_nxt  = free_head_r;
    free_count_nxt = free_count_r;
    page_total_nxt = page_total_r;
    cur_nxt        = cur_r;
    cnt_nxt        = cnt_r;
    rstat_nxt      = rstat_r;
    head_nxt       = head_r;
    unique case (cmd.op)
      pfla_pkg::OP_ACCEPT: begin
        rstat_nxt = pfla_pkg::RS_OK;
        head_nxt  = pfla_pkg::NONE_IDX;
      end
      pfla_pkg::OP_START_INIT: begin
        page_total_nxt = init_pages;
        free_count_nxt = init_pages;
        free_head_nxt  = (init_pages != '0) ? '0 : pfla_pkg::NONE_IDX;
        cnt_nxt        = '0;
      end
      pfla_pkg::OP_INIT_STEP: cnt_nxt = LW'(cnt_r + 1'b1);
      pfla_pkg::OP_START_ALLOC: begin
        cur_nxt = free_head_r;
        cnt_nxt = LW'(req_r[LW-1:0] - 1'b1);
      end
      pfla_pkg::OP_ALLOC_STEP: begin
        cur_nxt = rd_data_r;
        cnt_nxt = LW'(cnt_r - 1'b1);
      end
      pfla_pkg::OP_ALLOC_END: begin
        head_nxt       = free_head_r;
        free_head_nxt  = rd_data_r;
        free_count_nxt = LW'(free_count_r - req_r[LW-1:0]);
      end
      pfla_pkg::OP_START_FREE: begin
        cur_nxt = chain_r;
        cnt_nxt = LW'(1);
      end
      pfla_pkg::OP_FREE_STEP: begin
        cur_nxt = rd_data_r;
        cnt_nxt = LW'(cnt_r + 1'b1);
      end
      pfla_pkg::OP_FREE_END: begin
        free_head_nxt  = chain_r;
        free_count_nxt = (free_sum > {1'b0, page_total_r}) ? page_total_r : free_sum[LW-1:0];
      end
      pfla_pkg::OP_FAIL: rstat_nxt = cmd.fail_code;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_size_r   <= pfla_pkg::RAM_SIZE_RST;
      free_head_r  <= pfla_pkg::NONE_IDX;
      free_count_r <= '0;
      page_total_r <= '0;
    end else begin
      if (cfg_wr_en) ram_size_r <= cfg_wr_data;
      free_head_r  <= free_head_nxt;
      free_count_r <= free_count_nxt;
      page_total_r <= page_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    cnt_r   <= cnt_nxt;
    rstat_r <= rstat_nxt;
    head_r  <= head_nxt;
    if (cmd.op == pfla_pkg::OP_ACCEPT) begin
      func_r  <= pfla_pkg::func_t'(in_tuser);
      chain_r <= in_tdata[pfla_pkg::COUNT_W +: LW];
      if (pfla_pkg::func_t'(in_tuser) == pfla_pkg::FN_ALLOC_MIB) begin
        req_r <= RW'(in_tdata[pfla_pkg::COUNT_W-1:0]) << pfla_pkg::MIB_SHIFT;
      end else begin
        req_r <= RW'(in_tdata[pfla_pkg::COUNT_W-1:0]);
      end
    end
  end

  // result word
  assign head_ok    = (rstat_r == pfla_pkg::RS_OK) && (head_r != pfla_pkg::NONE_IDX);
  assign head_addr  = head_ok ? (pfla_pkg::HADDR_W'(pfla_pkg::BASE_ALIGNED) +
                                 (pfla_pkg::HADDR_W'(head_r) << pfla_pkg::PAGE_SHIFT)) : '0;
  assign free_bytes = pfla_pkg::FBYTES_W'(pfla_pkg::FBYTES_W'(free_count_r) << pfla_pkg::PAGE_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == pfla_pkg::OP_LOAD_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == pfla_pkg::OP_LOAD_OUT) begin
      out_user_r <= rstat_r;
      out_data_r <= {page_total_r, free_bytes, free_count_r, head_addr,
                     head_ok ? head_r : pfla_pkg::NONE_IDX};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

### hw/rtl/page_free_list_allocator.sv
// page_free_list_allocator: top level of the linked free-list page allocator
// depends on pfla_pkg, pfla_ctrl and pfla_dpath
`default_nettype none

// Page allocator over a singly linked free list of 4096 pages of 4 KiB each, placed from
// 1 MiB upwards. The list lives in a link memory with a write and a read port; a word on the
// input stream carries an operation in in_tuser: init builds the list from the configured
// RAM size, alloc by pages or by MiB detaches pages from the head, free prepends a
// returned chain. Every input word gives exactly one result word. Timing: one link is
// followed per cycle through the link memory's registered read port during a walk; a
// result that is not taken holds the block in its result state. One word is worked on
// at a time; the result sits in an output register, so the next word is taken while
// the previous result waits. Link entries not yet written by an init hold unknown
// data and are never followed. In-use marks of the pages are not kept, since nothing
// observable depends on them. The RAM size is written through cfg_wr_en/cfg_wr_data
// and must only change while the block is idle.

module page_free_list_allocator (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // input words
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [pfla_pkg::IN_TDATA_W-1:0]     in_tdata,   // count [15:0], chain_head [28:16]
  input  wire  [pfla_pkg::FUNC_W-1:0]         in_tuser,   // func [1:0]
  // result words
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [pfla_pkg::OUT_TDATA_W-1:0]    out_tdata,  // head_index [12:0],
                                                          // head_address [44:13],
                                                          // pages free [57:45],
                                                          // free_bytes [82:58],
                                                          // pages_total [95:83]
  output logic [1:0]                          out_tuser,  // status [1:0]
  // configuration
  input  wire                                 cfg_wr_en,
  input  wire  [pfla_pkg::RAM_W-1:0]          cfg_wr_data // ram size in bytes
);

  pfla_pkg::dp_cmd_t cmd;
  pfla_pkg::dp_sts_t sts;

  // sequencer: one state per phase of an item
  pfla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // link memory, list registers and result register
  pfla_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata)
  );

endmodule

`default_nettype wire
